// ----- rtl/switch_selected_led_pattern_sequencer_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the LED pattern sequencer
// Shared immediate-to-next and same-cycle implication checks on clk and rst.
// ----------------------------------------------------------------------------
`ifndef SWITCH_SELECTED_LED_PATTERN_SEQUENCER_TOP_MACROS_SVH
`define SWITCH_SELECTED_LED_PATTERN_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SSLPS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SSLPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sslps_pkg.sv -----
// ----------------------------------------------------------------------------
// sslps_pkg
// Mode codes, switch decode and the pattern tables of the LED sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sslps_pkg;

  typedef enum logic [2:0] {
    MODE_ALL_ON,
    MODE_COUNT,
    MODE_LEFT,
    MODE_RIGHT,
    MODE_PHASE
  } mode_t;

  localparam logic [15:0] ALL_ON = 16'hFFFF;

  localparam logic [7:0] MASK_COUNT = 8'hFE;
  localparam logic [7:0] CODE_ALL_ON = 8'h00;
  localparam logic [7:0] CODE_COUNT = 8'h02;
  localparam logic [7:0] MASK_LEFT = 8'hFA;
  localparam logic [7:0] CODE_LEFT = 8'h0A;
  localparam logic [7:0] MASK_RIGHT = 8'hE8;
  localparam logic [7:0] CODE_RIGHT = 8'h28;
  localparam logic [7:0] MASK_PHASE = 8'hA0;

  localparam logic [15:0] LEFT_TABLE [8] = '{
    16'h1234, 16'h2345, 16'h3456, 16'h4567,
    16'h5678, 16'h6781, 16'h7812, 16'h8123
  };

  localparam logic [15:0] RIGHT_TABLE [8] = '{
    16'h8765, 16'h1876, 16'h2187, 16'h3218,
    16'h4321, 16'h5432, 16'h6543, 16'h7654
  };

  localparam logic [15:0] PHASE_TABLE [4] = '{
    16'h1234, 16'hFFFF, 16'h5678, 16'hFFFF
  };

  // Priority decode of the switch bank; anything unmatched shows all on.
  function automatic mode_t decode_mode(input logic [7:0] sw);
    mode_t m;
    if ((sw & MASK_COUNT) == CODE_ALL_ON) begin
      m = MODE_ALL_ON;
    end else if ((sw & MASK_COUNT) == CODE_COUNT) begin
      m = MODE_COUNT;
    end else if ((sw & MASK_LEFT) == CODE_LEFT) begin
      m = MODE_LEFT;
    end else if ((sw & MASK_RIGHT) == CODE_RIGHT) begin
      m = MODE_RIGHT;
    end else if ((sw & MASK_PHASE) == MASK_PHASE) begin
      m = MODE_PHASE;
    end else begin
      m = MODE_ALL_ON;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/switch_selected_led_pattern_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// switch_selected_led_pattern_sequencer_top
// Picks an LED pattern mode from the switch bank for each accepted item.
// ----------------------------------------------------------------------------
//  Channel  Handshake            Payload
//  input    in_valid / in_stall  switches[7:0]
//  output   out_valid / out_stall led_word[15:0], long_hold
//
//  One item is accepted per clock cycle while the output is not stalled; its
//  result passes through the input register and then the result register.
//  Reset (rst, synchronous) empties both registers and loads the countdown
//  with 1:59 and every rotation and phase index with zero.
//  A stall on the output holds the result register; the input register then
//  fills, and in_stall rises only while both are occupied and the result is
//  still stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "switch_selected_led_pattern_sequencer_top_macros.svh"

module switch_selected_led_pattern_sequencer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  switches,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      led_word,
  output logic             long_hold
);

  // Input register: holds one item until the result register can take it.
  logic       s1_valid;
  logic [7:0] s1_sw;

  // Mode state. Only the mode chosen by an item advances.
  logic       count_minutes;
  logic [2:0] count_tens;
  logic [3:0] count_units;
  logic [2:0] left_idx;
  logic [2:0] right_idx;
  logic [1:0] phase_idx;

  logic       count_minutes_next;
  logic [2:0] count_tens_next;
  logic [3:0] count_units_next;

  logic [15:0] word_next;
  logic        long_hold_next;
  logic        out_free;
  logic        adv;
  sslps_pkg::mode_t mode;

  // The result register can take a new item when empty or being emptied.
  assign out_free = !out_valid || !out_stall;
  assign adv      = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign mode     = sslps_pkg::decode_mode(s1_sw);

  // BCD countdown with borrows; from 0:00 it wraps back to 1:59.
  always_comb begin
    count_minutes_next = count_minutes;
    count_tens_next    = count_tens;
    count_units_next   = count_units - 4'd1;
    if (count_units == 4'd0) begin
      count_units_next = 4'd9;
      count_tens_next  = count_tens - 3'd1;
      if (count_tens == 3'd0) begin
        count_tens_next    = 3'd5;
        count_minutes_next = !count_minutes;
      end
    end
  end

  // The word shown is the state as it stands, before it advances.
  always_comb begin
    long_hold_next = 1'b1;
    word_next      = sslps_pkg::ALL_ON;
    unique case (mode)
      sslps_pkg::MODE_ALL_ON: word_next = sslps_pkg::ALL_ON;
      sslps_pkg::MODE_COUNT: begin
        word_next      = {7'd0, count_minutes, 1'b0, count_tens, count_units};
        long_hold_next = 1'b0;
      end
      sslps_pkg::MODE_LEFT:  word_next = sslps_pkg::LEFT_TABLE[left_idx];
      sslps_pkg::MODE_RIGHT: word_next = sslps_pkg::RIGHT_TABLE[right_idx];
      sslps_pkg::MODE_PHASE: word_next = sslps_pkg::PHASE_TABLE[phase_idx];
      default:               word_next = sslps_pkg::ALL_ON;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      count_minutes <= 1'b1;
      count_tens    <= 3'd5;
      count_units   <= 4'd9;
      left_idx      <= 3'd0;
      right_idx     <= 3'd0;
      phase_idx     <= 2'd0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
      if (adv) begin
        case (mode)
          sslps_pkg::MODE_COUNT: begin
            count_minutes <= count_minutes_next;
            count_tens    <= count_tens_next;
            count_units   <= count_units_next;
          end
          sslps_pkg::MODE_LEFT:  left_idx  <= left_idx + 3'd1;
          sslps_pkg::MODE_RIGHT: right_idx <= right_idx + 3'd1;
          sslps_pkg::MODE_PHASE: phase_idx <= phase_idx + 2'd1;
          default: ;
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_sw <= switches;
    end
    if (adv) begin
      led_word  <= word_next;
      long_hold <= long_hold_next;
    end
  end

  `SSLPS_ASSERT_SAME(a_digits_range, 1'b1, (count_tens <= 3'd5) && (count_units <= 4'd9), "countdown digit out of range")
  `SSLPS_ASSERT_NEXT(a_count_short, adv && (mode == sslps_pkg::MODE_COUNT), out_valid && !long_hold, "countdown item without short hold")
  `SSLPS_ASSERT_NEXT(a_left_hold, !(adv && (mode == sslps_pkg::MODE_LEFT)), $stable(left_idx), "left index moved without a left item")
  `SSLPS_ASSERT_SAME(a_stall_full, in_stall, s1_valid && out_valid, "input stalled with a free slot")

endmodule

`default_nettype wire

// ----- dv/tb_switch_selected_led_pattern_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// tb_switch_selected_led_pattern_sequencer_top
// Self-checking bench for the switch-selected LED pattern sequencer. Switch
// items are pushed through the valid/stall input, and every LED result is
// compared against a cycle-free predictor of the five display modes. Both
// sides idle and stall at random, apart from one calm countdown stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
  logic [15:0] word;
  logic        hold;
} led_result_t;

// Predicts the LED word for each accepted switch item and holds the results
// still owed by the block, oldest first.
class led_pattern_scoreboard;
  bit          cd_minute;
  bit [2:0]    cd_tens;
  bit [3:0]    cd_units;
  bit [2:0]    left_idx;
  bit [2:0]    right_idx;
  bit [1:0]    phase_idx;
  bit [15:0]   left_pat [8];
  bit [15:0]   right_pat [8];
  bit [15:0]   phase_pat [4];
  led_result_t awaited_leds [$];
  int unsigned errors;
  int unsigned items;
  int unsigned results;
  int unsigned reloads;
  int unsigned mode_hits [5];

  function new();
    cd_minute = 1'b1;
    cd_tens   = 3'd5;
    cd_units  = 4'd9;
    left_idx  = '0;
    right_idx = '0;
    phase_idx = '0;
    left_pat  = '{16'h1234, 16'h2345, 16'h3456, 16'h4567,
                  16'h5678, 16'h6781, 16'h7812, 16'h8123};
    right_pat = '{16'h8765, 16'h1876, 16'h2187, 16'h3218,
                  16'h4321, 16'h5432, 16'h6543, 16'h7654};
    phase_pat = '{16'h1234, 16'hFFFF, 16'h5678, 16'hFFFF};
    foreach (mode_hits[i]) mode_hits[i] = 0;
  endfunction

  function int pending();
    return awaited_leds.size();
  endfunction

  // Decodes the switches, works out the LED word and advances the state of
  // the selected mode only.
  function void note_switches(logic [7:0] sw);
    sslps_pkg::mode_t m;
    led_result_t      r;
    if ((sw & sslps_pkg::MASK_COUNT) == sslps_pkg::CODE_ALL_ON) begin
      m = sslps_pkg::MODE_ALL_ON;
    end else if ((sw & sslps_pkg::MASK_COUNT) == sslps_pkg::CODE_COUNT) begin
      m = sslps_pkg::MODE_COUNT;
    end else if ((sw & sslps_pkg::MASK_LEFT) == sslps_pkg::CODE_LEFT) begin
      m = sslps_pkg::MODE_LEFT;
    end else if ((sw & sslps_pkg::MASK_RIGHT) == sslps_pkg::CODE_RIGHT) begin
      m = sslps_pkg::MODE_RIGHT;
    end else if ((sw & sslps_pkg::MASK_PHASE) == sslps_pkg::MASK_PHASE) begin
      m = sslps_pkg::MODE_PHASE;
    end else begin
      m = sslps_pkg::MODE_ALL_ON;
    end
    r.word = sslps_pkg::ALL_ON;
    r.hold = 1'b1;
    case (m)
      sslps_pkg::MODE_COUNT: begin
        r.word = {7'b0, cd_minute, 1'b0, cd_tens, cd_units};
        r.hold = 1'b0;
        if (cd_units != 4'd0) begin
          cd_units = cd_units - 4'd1;
        end else begin
          cd_units = 4'd9;
          if (cd_tens != 3'd0) begin
            cd_tens = cd_tens - 3'd1;
          end else begin
            cd_tens = 3'd5;
            if (cd_minute) begin
              cd_minute = 1'b0;
            end else begin
              cd_minute = 1'b1;
              reloads++;
            end
          end
        end
      end
      sslps_pkg::MODE_LEFT: begin
        r.word = left_pat[left_idx];
        left_idx = left_idx + 3'd1;
      end
      sslps_pkg::MODE_RIGHT: begin
        r.word = right_pat[right_idx];
        right_idx = right_idx + 3'd1;
      end
      sslps_pkg::MODE_PHASE: begin
        r.word = phase_pat[phase_idx];
        phase_idx = phase_idx + 2'd1;
      end
      default: begin
      end
    endcase
    mode_hits[int'(m)]++;
    items++;
    awaited_leds.push_back(r);
  endfunction

  task report_mismatch(string what, logic [15:0] want, logic [15:0] got);
    errors++;
    if (errors <= 30) begin
      $display("mismatch on result %0d: %s expected %h, got %h",
               results, what, want, got);
    end
  endtask

  task check_led(logic [15:0] word, logic hold);
    led_result_t e;
    results++;
    if (awaited_leds.size() == 0) begin
      report_mismatch("led_word with nothing awaited", 16'h0, word);
    end else begin
      e = awaited_leds.pop_front();
      if (word !== e.word) report_mismatch("led_word", e.word, word);
      if (hold !== e.hold) report_mismatch("long_hold", 16'(e.hold), 16'(hold));
    end
  endtask
endclass

module tb_switch_selected_led_pattern_sequencer_top;

  localparam int unsigned CYCLE_LIMIT = 60000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  switches = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] led_word;
  logic        long_hold;

  // While calm is set neither side idles nor stalls.
  bit          calm = 1'b0;
  int unsigned cycle_count = 0;

  led_pattern_scoreboard sb;

  switch_selected_led_pattern_sequencer_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .switches  (switches),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .led_word  (led_word),
    .long_hold (long_hold)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog: stops the run with an error when the cycle counter reaches CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d results still owed",
               cycle_count, sb.pending());
      $display("[switch_selected_led_pattern_sequencer_top] ERROR");
      $finish;
    end
  end

  // Result side. Every signal here changes only through nonblocking updates,
  // so the values read at the edge are the ones that were present before it.
  // A result counts as taken when out_valid is high and our stall was low.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_led(led_word, long_hold);
      out_stall <= !calm && ($urandom_range(0, 99) < 27);
    end
  end

  // Offers one switch item, after an optional random gap, and holds it until
  // the block takes it. The item is handed to the predictor at that edge.
  task send_item(input logic [7:0] sw);
    while (!calm && ($urandom_range(0, 99) < 27)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    switches <= sw;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_switches(sw);
  endtask

  // A random mix with most items steered into one of the real modes; the
  // free bits of each mode's code are random so every switch bit toggles.
  task send_mixed(input int n);
    logic [7:0] r;
    int         pick;
    for (int i = 0; i < n; i++) begin
      r    = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_item(sslps_pkg::CODE_COUNT | (r & ~sslps_pkg::MASK_COUNT));
      end else if (pick < 45) begin
        send_item(sslps_pkg::CODE_LEFT | (r & ~sslps_pkg::MASK_LEFT));
      end else if (pick < 60) begin
        send_item(sslps_pkg::CODE_RIGHT | (r & ~sslps_pkg::MASK_RIGHT));
      end else if (pick < 75) begin
        send_item(sslps_pkg::MASK_PHASE | (r & ~sslps_pkg::MASK_PHASE));
      end else if (pick < 82) begin
        send_item(sslps_pkg::CODE_ALL_ON | (r & ~sslps_pkg::MASK_COUNT));
      end else begin
        send_item(r);
      end
    end
  endtask

  task wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    // Opening set: both all-on codes, both countdown codes, the corners of
    // the left and right rotation codes, phase codes including all ones, and
    // several values that fall through every mask and show all on.
    logic [7:0] opening_set [22];
    opening_set = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h02, 8'h0A, 8'h0B, 8'h0E,
                    8'h0F, 8'h28, 8'h29, 8'h3F, 8'h2E, 8'hA0, 8'hFF, 8'hF5,
                    8'hDF, 8'h04, 8'h80, 8'h06, 8'h7F, 8'h0A};
    sb = new();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_set[i]) send_item(opening_set[i]);
    send_mixed(300);

    // Hold the input back until the block has delivered everything it owes,
    // then run an unbroken countdown long enough to pass through 0:00 and
    // reload 1:59, with neither side idling.
    in_valid <= 1'b0;
    wait_drained();
    calm <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < 130; i++) begin
      send_item(sslps_pkg::CODE_COUNT | (8'($urandom) & ~sslps_pkg::MASK_COUNT));
    end
    calm <= 1'b0;

    send_mixed(270);

    // Drain, then keep the clock running past the two register stages so that a
    // stray extra result would still be caught.
    in_valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);

    $display("covered %0d items, %0d results: all-on %0d, countdown %0d,",
             sb.items, sb.results, sb.mode_hits[int'(sslps_pkg::MODE_ALL_ON)],
             sb.mode_hits[int'(sslps_pkg::MODE_COUNT)]);
    $display("left %0d, right %0d, phase %0d; reloaded from 0:00 %0d times; %0d mismatches",
             sb.mode_hits[int'(sslps_pkg::MODE_LEFT)],
             sb.mode_hits[int'(sslps_pkg::MODE_RIGHT)],
             sb.mode_hits[int'(sslps_pkg::MODE_PHASE)], sb.reloads, sb.errors);
    if (sb.errors == 0) begin
      $display("[switch_selected_led_pattern_sequencer_top] OK");
    end else begin
      $display("[switch_selected_led_pattern_sequencer_top] ERROR");
    end
    $finish;
  end

endmodule
